// ----- hdl/fsr_pkg.sv -----
package fsr_pkg;

  localparam int DEPTH     = 16;
  localparam int KEY_WIDTH = 16;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam logic [1:0] REQ_ENQ    = 2'd0;
  localparam logic [1:0] REQ_DEQ    = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;
  localparam logic [1:0] REQ_REMOVE = 2'd3;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_ENQ    = 2'd1;
  localparam logic [1:0] CELL_DEQ    = 2'd2;
  localparam logic [1:0] CELL_REMOVE = 2'd3;

  typedef struct packed {
    logic [1:0]           mode;
    logic [KEY_WIDTH-1:0] key;
  } cell_cmd_t;

endpackage

// ----- hdl/fsr_if.sv -----
interface fsr_req_if import fsr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [KEY_WIDTH-1:0] key_value;

  modport source (output valid, output req_type, output key_value, input ready);
  modport sink   (input valid, input req_type, input key_value, output ready);
endinterface

interface fsr_rsp_if import fsr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic                 found;
  logic [KEY_WIDTH-1:0] head_value;
  logic [CNT_W-1:0]     occupancy;

  modport source (output valid, output status, output found, output head_value,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input found, input head_value,
                  input occupancy, output ready);
endinterface

// ----- hdl/fsr_cell.sv -----
module fsr_cell import fsr_pkg::*; (
  input  logic                 clk,
  input  cell_cmd_t            cmd,
  input  logic                 live,
  input  logic                 tail,
  input  logic                 kill_in,
  input  logic [KEY_WIDTH-1:0] nbr_key,
  output logic                 kill_out,
  output logic                 hit,
  output logic [KEY_WIDTH-1:0] key
);

  assign hit      = live && (key == cmd.key);
  assign kill_out = kill_in || (hit && (cmd.mode == CELL_REMOVE));

  always_ff @(posedge clk) begin
    case (cmd.mode)
      CELL_ENQ: begin
        if (tail) begin
          key <= cmd.key;
        end
      end
      CELL_DEQ, CELL_REMOVE: begin
        if (kill_out) begin
          key <= nbr_key;
        end
      end
      default: begin
        key <= key;
      end
    endcase
  end

endmodule

// ----- hdl/fifo_with_search_and_remove_unit.sv -----
// Channel  Dir  Beat contents
// req      in   req_type, key_value
// rsp      out  status, found, head_value, occupancy
//
// Enqueue, dequeue and query register their result when accepted; remove
// stays in S_REMOVE while a match remains; the row drops one match per cycle.
// rst clears occupancy, state and rsp.valid; cell keys are not reset.
// A request is taken only when idle and the rsp register is free or draining.
// A stalled rsp holds the result and the end of a remove.
module fifo_with_search_and_remove_unit import fsr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  fsr_req_if.sink req,
  fsr_rsp_if.source rsp
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_REMOVE = 1'b1;

  logic                 state, state_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [KEY_WIDTH-1:0] rm_key;
  logic                 rm_found, rm_found_next;
  logic                 out_valid;
  logic [1:0]           out_status;
  logic                 out_found;
  logic [KEY_WIDTH-1:0] out_head;
  logic [CNT_W-1:0]     out_occ;

  logic                 emit;
  logic [1:0]           e_status;
  logic                 e_found;
  logic [KEY_WIDTH-1:0] e_head;

  cell_cmd_t            cmd;
  logic [KEY_WIDTH-1:0] cell_key [DEPTH];
  logic [DEPTH:0]       kill;
  logic [DEPTH-1:0]     hit, live, tail;

  logic out_free, accept, full, empty, rm_hit;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign rm_hit    = (state == S_REMOVE) && kill[DEPTH];

  always_comb begin
    cmd.mode = CELL_HOLD;
    cmd.key  = req.key_value;
    if (state == S_REMOVE) begin
      cmd.mode = CELL_REMOVE;
      cmd.key  = rm_key;
    end else if (accept) begin
      case (req.req_type)
        REQ_ENQ: cmd.mode = full ? CELL_HOLD : CELL_ENQ;
        REQ_DEQ: cmd.mode = empty ? CELL_HOLD : CELL_DEQ;
        default: cmd.mode = CELL_HOLD;
      endcase
    end
  end

  assign kill[0] = (cmd.mode == CELL_DEQ);

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      assign live[g] = (CNT_W'(g) < count);
      assign tail[g] = (CNT_W'(g) == count);
      fsr_cell u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .live     (live[g]),
        .tail     (tail[g]),
        .kill_in  (kill[g]),
        .nbr_key  ((g == DEPTH - 1) ? KEY_WIDTH'(0) : cell_key[(g + 1) % DEPTH]),
        .kill_out (kill[g + 1]),
        .hit      (hit[g]),
        .key      (cell_key[g])
      );
    end
  endgenerate

  always_comb begin
    state_next    = state;
    count_next    = count;
    rm_found_next = rm_found;
    emit          = 1'b0;
    e_status      = STAT_DONE;
    e_found       = 1'b0;
    e_head        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.req_type)
            REQ_ENQ: begin
              emit = 1'b1;
              if (full) begin
                e_status = STAT_FULL;
              end else begin
                count_next = count + CNT_W'(1);
              end
            end
            REQ_DEQ: begin
              emit = 1'b1;
              if (empty) begin
                e_status = STAT_EMPTY;
              end else begin
                count_next = count - CNT_W'(1);
                e_head     = cell_key[0];
              end
            end
            REQ_QUERY: begin
              emit    = 1'b1;
              e_found = |hit;
            end
            default: begin
              rm_found_next = 1'b0;
              state_next    = S_REMOVE;
            end
          endcase
        end
      end
      S_REMOVE: begin
        if (rm_hit) begin
          count_next    = count - CNT_W'(1);
          rm_found_next = 1'b1;
        end else if (out_free) begin
          emit       = 1'b1;
          e_found    = rm_found;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rm_found  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      rm_found <= rm_found_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req.req_type == REQ_REMOVE)) begin
      rm_key <= req.key_value;
    end
    if (emit) begin
      out_status <= e_status;
      out_found  <= e_found;
      out_head   <= e_head;
      out_occ    <= count_next;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.found      = out_found;
  assign rsp.head_value = out_head;
  assign rsp.occupancy  = out_occ;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("occupancy above capacity");

  a_remove_step: assert property (@(posedge clk) disable iff (rst)
    rm_hit |=> (count == $past(count) - CNT_W'(1)))
    else $error("remove step did not drop one entry");

  a_enq_grow: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == REQ_ENQ && !full) |=> (count == $past(count) + CNT_W'(1)))
    else $error("enqueue did not grow occupancy");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result overwrote a pending beat");

endmodule
